>>> design/mrrs_pkg.sv
// shared types, codes and defaults of the multicore round-robin scheduler
// no dependencies
`timescale 1ns / 1ps

package mrrs_pkg;

  localparam int DEF_MAX_CORES     = 4;
  localparam int DEF_QUEUE_DEPTH   = 16;
  localparam int DEF_BLOCKED_DEPTH = 16;

  localparam int TASK_W  = 10;
  localparam int QUANT_W = 16;
  localparam int CFG_W   = 16;
  localparam int CFGI_W  = 3;
  localparam int AC_W    = 3;
  localparam int LOAD_W  = 10;
  localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
  localparam logic [AC_W-1:0] AC_RESET = 3'd4;
  localparam logic [QUANT_W-1:0] QUANT_RESET = 16'd10;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_UNBLOCK = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RSN_PLAIN = 2'd0,
    RSN_BLOCK = 2'd1,
    RSN_EXIT  = 2'd2,
    RSN_OTHER = 2'd3
  } reason_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_QFULL     = 2'd1,
    ST_BLKFULL   = 2'd2,
    ST_UNKNOWN   = 2'd3
  } status_t;

  typedef enum logic [CFGI_W-1:0] {
    CFG_ACTIVE = 3'd0,
    CFG_QUANT0 = 3'd1,
    CFG_QUANT1 = 3'd2,
    CFG_QUANT2 = 3'd3,
    CFG_QUANT3 = 3'd4
  } cfg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic do_load;
    logic scan_step;
    logic scan_miss;
    logic do_unblk;
    logic do_tick;
    logic do_pop;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_end;
    logic scan_hit;
    logic tick_pop;
  } dp_stat_t;

endpackage

>>> design/mrrs_ctrl.sv
// sequencing state machine of the scheduler
// depends on mrrs_pkg
`timescale 1ns / 1ps

module mrrs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         cmd,
  input  logic               out_ready,
  input  mrrs_pkg::dp_stat_t stat,
  output mrrs_pkg::ctrl_cmd_t ctl,
  output logic               in_ready,
  output logic               out_valid
);
  import mrrs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_SCAN, S_UNBLK, S_TICK, S_POP, S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    ctl = '0;
    ctl.latch = (state == S_IDLE) && in_valid && in_ready;
    unique case (state)
      S_LOAD:  ctl.do_load = 1'b1;
      S_SCAN: begin
        if (stat.scan_end) ctl.scan_miss = 1'b1;
        else if (!stat.scan_hit) ctl.scan_step = 1'b1;
      end
      S_UNBLK: ctl.do_unblk = 1'b1;
      S_TICK:  ctl.do_tick = 1'b1;
      S_POP:   ctl.do_pop = 1'b1;
      S_DONE:  ctl.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      // new result loaded, or the held one taken
      if (ctl.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            in_ready <= 1'b0;
            unique case (cmd_t'(cmd))
              CMD_LOAD:    state <= S_LOAD;
              CMD_UNBLOCK: state <= S_SCAN;
              CMD_TICK:    state <= S_TICK;
              default:     state <= S_DONE;
            endcase
          end
        end
        S_LOAD:  state <= S_DONE;
        S_SCAN: begin
          if (stat.scan_end) state <= S_DONE;
          else if (stat.scan_hit) state <= S_UNBLK;
        end
        S_UNBLK: state <= S_DONE;
        S_TICK:  state <= stat.tick_pop ? S_POP : S_DONE;
        S_POP:   state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            in_ready  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/mrrs_dp.sv
// scheduler datapath: config, per-core queues and counters, blocked table
// depends on mrrs_pkg
`timescale 1ns / 1ps

module mrrs_dp #(
  parameter int MAX_CORES     = mrrs_pkg::DEF_MAX_CORES,
  parameter int QUEUE_DEPTH   = mrrs_pkg::DEF_QUEUE_DEPTH,
  parameter int BLOCKED_DEPTH = mrrs_pkg::DEF_BLOCKED_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mrrs_pkg::ctrl_cmd_t          ctl,
  output mrrs_pkg::dp_stat_t           stat,
  input  logic                         cfg_wr_en,
  input  logic [mrrs_pkg::CFGI_W-1:0]  cfg_index,
  input  logic [mrrs_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic [mrrs_pkg::TASK_W-1:0]  task_id,
  input  logic [1:0]                   core_sel,
  input  logic [1:0]                   tick_reason,
  output logic [mrrs_pkg::TASK_W-1:0]  run_task,
  output logic                         run_idle,
  output logic [1:0]                   chosen_core,
  output logic [1:0]                   status
);
  import mrrs_pkg::*;

  localparam int CW  = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW  = $clog2(2 * QUEUE_DEPTH);
  localparam int AW  = (MAX_CORES * QUEUE_DEPTH > 1) ? $clog2(MAX_CORES * QUEUE_DEPTH) : 1;
  localparam int BW  = (BLOCKED_DEPTH > 1) ? $clog2(BLOCKED_DEPTH) : 1;
  localparam int BCW = $clog2(BLOCKED_DEPTH + 1);
  localparam logic [FW-1:0]  FULL   = FW'(QUEUE_DEPTH);
  localparam logic [BCW-1:0] BFULL  = BCW'(BLOCKED_DEPTH);

  // configuration
  logic [AC_W-1:0]    active_cores;
  logic [QUANT_W-1:0] quantum [4];

  // per-core state
  logic [LOAD_W-1:0]  load_count [MAX_CORES];
  logic [FW-1:0]      fifo_fill  [MAX_CORES];
  logic [QW-1:0]      fifo_head  [MAX_CORES];
  logic               run_valid  [MAX_CORES];
  logic [TASK_W-1:0]  run_id     [MAX_CORES];
  logic [QUANT_W-1:0] slice_left [MAX_CORES];

  // blocked table, packed in arrival order
  logic [TASK_W-1:0]  blk_task [BLOCKED_DEPTH];
  logic [CW-1:0]      blk_core [BLOCKED_DEPTH];
  logic [BCW-1:0]     blk_count;
  logic [BCW-1:0]     scan_idx;

  // latched item
  logic [TASK_W-1:0]  l_task;
  logic [1:0]         l_core;
  logic [1:0]         l_reason;
  logic               pop_requeue;

  // pending result
  logic [TASK_W-1:0]  res_task;
  logic               res_idle;
  logic [1:0]         res_core;
  logic [1:0]         res_status;

  // ready queues
  logic [TASK_W-1:0]  ready_fifo [MAX_CORES * QUEUE_DEPTH];
  logic [TASK_W-1:0]  rdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [TASK_W-1:0]  mem_wdata;

  function automatic logic [AW-1:0] qaddr(input logic [CW-1:0] c, input logic [QW-1:0] p);
    int a;
    a = int'(c) * QUEUE_DEPTH + int'(p);
    return AW'(a);
  endfunction

  function automatic logic [QW-1:0] wrap_add(input logic [QW-1:0] h, input logic [FW-1:0] n);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(n);
    if (s >= SW'(QUEUE_DEPTH)) s = s - SW'(QUEUE_DEPTH);
    return QW'(s);
  endfunction

  // placement: least loaded among active cores
  logic [CW-1:0] best;
  int            n_act;
  always_comb begin
    if (active_cores == '0) n_act = 1;
    else if (int'(active_cores) > MAX_CORES) n_act = MAX_CORES;
    else n_act = int'(active_cores);
    best = '0;
    for (int i = 1; i < MAX_CORES; i++) begin
      if (i < n_act && load_count[i] < load_count[best]) best = CW'(i);
    end
  end

  logic [BW-1:0]  sidx;
  logic [CW-1:0]  ucore;
  logic [CW-1:0]  tc;
  logic           core_ok;
  logic           tick_disp;
  logic [QW-1:0]  tail_best;
  logic [QW-1:0]  tail_u;
  logic [QW-1:0]  tail_t;

  assign sidx      = scan_idx[BW-1:0];
  assign ucore     = blk_core[sidx];
  assign tc        = CW'(l_core);
  assign core_ok   = int'(l_core) < MAX_CORES;
  assign tick_disp = !run_valid[tc] || l_reason == RSN_BLOCK || l_reason == RSN_EXIT;
  assign tail_best = wrap_add(fifo_head[best], fifo_fill[best]);
  assign tail_u    = wrap_add(fifo_head[ucore], fifo_fill[ucore]);
  assign tail_t    = wrap_add(fifo_head[tc], fifo_fill[tc]);

  assign stat.scan_end = scan_idx >= blk_count;
  assign stat.scan_hit = blk_task[sidx] == l_task;
  assign stat.tick_pop = core_ok && fifo_fill[tc] != '0 &&
                         (tick_disp || slice_left[tc] <= QUANT_W'(1));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = l_task;
    mem_re    = ctl.do_tick && stat.tick_pop;
    mem_raddr = qaddr(tc, fifo_head[tc]);
    if (ctl.do_load && fifo_fill[best] != FULL) begin
      mem_we    = 1'b1;
      mem_waddr = qaddr(best, tail_best);
    end else if (ctl.do_unblk && fifo_fill[ucore] != FULL) begin
      mem_we    = 1'b1;
      mem_waddr = qaddr(ucore, tail_u);
    end else if (ctl.do_pop && pop_requeue) begin
      mem_we    = 1'b1;
      mem_waddr = qaddr(tc, tail_t);
      mem_wdata = run_id[tc];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) ready_fifo[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= ready_fifo[mem_raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      l_task     <= task_id;
      l_core     <= core_sel;
      l_reason   <= tick_reason;
      res_task   <= '0;
      res_idle   <= 1'b0;
      res_core   <= '0;
      res_status <= ST_OK;
    end
    if (ctl.do_load) begin
      res_core <= 2'(best);
      if (fifo_fill[best] == FULL) res_status <= ST_QFULL;
    end
    if (ctl.scan_miss) res_status <= ST_UNKNOWN;
    if (ctl.do_unblk) begin
      res_core <= 2'(ucore);
      if (fifo_fill[ucore] == FULL) res_status <= ST_QFULL;
    end
    if (ctl.do_tick) begin
      if (!core_ok) begin
        res_idle <= 1'b1;
      end else begin
        if (run_valid[tc] && l_reason == RSN_BLOCK && blk_count == BFULL)
          res_status <= ST_BLKFULL;
        if (!stat.tick_pop) begin
          if (tick_disp) res_idle <= 1'b1;
          else res_task <= run_id[tc];
        end
        pop_requeue <= !tick_disp;
      end
    end
    if (ctl.do_pop) res_task <= rdata;
    if (ctl.out_load) begin
      run_task    <= res_task;
      run_idle    <= res_idle;
      chosen_core <= res_core;
      status      <= res_status;
    end
  end

  // scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      active_cores <= AC_RESET;
      for (int q = 0; q < 4; q++) quantum[q] <= QUANT_RESET;
      for (int c = 0; c < MAX_CORES; c++) begin
        load_count[c] <= '0;
        fifo_fill[c]  <= '0;
        fifo_head[c]  <= '0;
        run_valid[c]  <= 1'b0;
        run_id[c]     <= '0;
        slice_left[c] <= '0;
      end
      blk_count <= '0;
      scan_idx  <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_ACTIVE: active_cores <= cfg_wdata[AC_W-1:0];
          CFG_QUANT0: quantum[0] <= cfg_wdata;
          CFG_QUANT1: quantum[1] <= cfg_wdata;
          CFG_QUANT2: quantum[2] <= cfg_wdata;
          CFG_QUANT3: quantum[3] <= cfg_wdata;
          default: ;
        endcase
      end
      if (ctl.latch) scan_idx <= '0;
      if (ctl.scan_step) scan_idx <= scan_idx + 1'b1;

      if (ctl.do_load && fifo_fill[best] != FULL) begin
        fifo_fill[best] <= fifo_fill[best] + 1'b1;
        if (load_count[best] != LOAD_MAX) load_count[best] <= load_count[best] + 1'b1;
      end

      if (ctl.do_unblk && fifo_fill[ucore] != FULL) begin
        fifo_fill[ucore] <= fifo_fill[ucore] + 1'b1;
        for (int i = 0; i < BLOCKED_DEPTH - 1; i++) begin
          if (i >= int'(scan_idx)) begin
            blk_task[i] <= blk_task[i+1];
            blk_core[i] <= blk_core[i+1];
          end
        end
        blk_count <= blk_count - 1'b1;
      end

      if (ctl.do_tick && core_ok) begin
        if (run_valid[tc] && l_reason == RSN_BLOCK && blk_count != BFULL) begin
          blk_task[blk_count[BW-1:0]] <= run_id[tc];
          blk_core[blk_count[BW-1:0]] <= tc;
          blk_count <= blk_count + 1'b1;
        end
        if (run_valid[tc] && l_reason == RSN_EXIT && load_count[tc] != '0)
          load_count[tc] <= load_count[tc] - 1'b1;
        if (tick_disp) begin
          slice_left[tc] <= quantum[l_core];
          if (fifo_fill[tc] == '0) begin
            run_valid[tc] <= 1'b0;
            run_id[tc]    <= '0;
          end
        end else if (slice_left[tc] <= QUANT_W'(1)) begin
          slice_left[tc] <= quantum[l_core];
        end else begin
          slice_left[tc] <= slice_left[tc] - 1'b1;
        end
      end

      if (ctl.do_pop) begin
        run_id[tc]    <= rdata;
        run_valid[tc] <= 1'b1;
        fifo_head[tc] <= wrap_add(fifo_head[tc], FW'(1));
        if (!pop_requeue) fifo_fill[tc] <= fifo_fill[tc] - 1'b1;
      end
    end
  end

endmodule

>>> design/multicore_round_robin_scheduler_top.sv
// top level of the multicore round-robin scheduler
// depends on mrrs_pkg, mrrs_ctrl and mrrs_dp
`timescale 1ns / 1ps

// Per-core round-robin scheduler. One item is handled at a time: a load passes
// through the load state, a tick through the tick state and, when a task is
// taken from a ready queue, a pop state that uses the registered read of the
// queue memory; an unblock searches the blocked table one entry a cycle and,
// on a match, passes through the unblock state; every item then waits in the
// done state until the output register is free.
// The result sits in an output register, so a new item can be accepted while
// it waits to be taken.
// Configuration may be written whenever no item is in flight.
module multicore_round_robin_scheduler_top #(
  parameter int MAX_CORES     = mrrs_pkg::DEF_MAX_CORES,
  parameter int QUEUE_DEPTH   = mrrs_pkg::DEF_QUEUE_DEPTH,
  parameter int BLOCKED_DEPTH = mrrs_pkg::DEF_BLOCKED_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write port
  input  logic                        cfg_wr_en,
  input  logic [mrrs_pkg::CFGI_W-1:0] cfg_index,
  input  logic [mrrs_pkg::CFG_W-1:0]  cfg_wdata,
  // input items
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  cmd,
  input  logic [mrrs_pkg::TASK_W-1:0] task_id,
  input  logic [1:0]                  core_sel,
  input  logic [1:0]                  tick_reason,
  // result items
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mrrs_pkg::TASK_W-1:0] run_task,
  output logic                        run_idle,
  output logic [1:0]                  chosen_core,
  output logic [1:0]                  status
);
  import mrrs_pkg::*;

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  // sequencer: accept, execute, optional queue pop, deliver
  mrrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  // queues, counters, blocked table and output register
  mrrs_dp #(
    .MAX_CORES     (MAX_CORES),
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .BLOCKED_DEPTH (BLOCKED_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .task_id     (task_id),
    .core_sel    (core_sel),
    .tick_reason (tick_reason),
    .run_task    (run_task),
    .run_idle    (run_idle),
    .chosen_core (chosen_core),
    .status      (status)
  );

endmodule

>>> design/mrrs_checker.sv
// port-level checks of the scheduler, bound to the top level
// depends on mrrs_pkg and multicore_round_robin_scheduler_top
`timescale 1ns / 1ps

module mrrs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mrrs_pkg::TASK_W-1:0] run_task,
  input logic                        run_idle,
  input logic [1:0]                  chosen_core,
  input logic [1:0]                  status
);
  import mrrs_pkg::*;

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another in flight");

  // idle core reports no task and no placement
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_idle |-> run_task == '0 && chosen_core == '0)
    else $error("idle result carries task or core");

  // unknown unblock changes nothing and names no core
  a_unknown: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_UNKNOWN |-> chosen_core == '0 && !run_idle && run_task == '0)
    else $error("unknown unblock result not clean");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(run_task) && $stable(status))
    else $error("stalled result changed");

endmodule

bind multicore_round_robin_scheduler_top mrrs_checker u_mrrs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .run_task    (run_task),
  .run_idle    (run_idle),
  .chosen_core (chosen_core),
  .status      (status)
);

>>> bench/multicore_round_robin_scheduler_top_tb.sv
// self-checking bench for the multicore round-robin scheduler top level
// depends on mrrs_pkg and multicore_round_robin_scheduler_top
`timescale 1ns / 1ps

module multicore_round_robin_scheduler_top_tb;
  import mrrs_pkg::*;

  localparam int NCORE = 4;
  localparam int QDEP  = 16;
  localparam int BDEP  = 16;

  typedef struct packed {
    logic [TASK_W-1:0] task_n;
    logic              idle;
    logic [1:0]        core;
    logic [1:0]        stat;
  } sched_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFGI_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] cmd = '0;
  logic [TASK_W-1:0] task_id = '0;
  logic [1:0] core_sel = '0;
  logic [1:0] tick_reason = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [TASK_W-1:0] run_task;
  logic run_idle;
  logic [1:0] chosen_core;
  logic [1:0] status;

  multicore_round_robin_scheduler_top i_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .task_id(task_id), .core_sel(core_sel), .tick_reason(tick_reason),
    .out_valid(out_valid), .out_ready(out_ready),
    .run_task(run_task), .run_idle(run_idle),
    .chosen_core(chosen_core), .status(status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // scheduler mirror: configuration and state
  logic [AC_W-1:0]    m_active;
  logic [QUANT_W-1:0] m_quant [NCORE];
  logic [TASK_W-1:0]  m_fifo [NCORE][QDEP];
  int                 m_fill [NCORE];
  int                 m_head [NCORE];
  int                 m_load [NCORE];
  logic               m_run_v [NCORE];
  logic [TASK_W-1:0]  m_run_id [NCORE];
  int                 m_slice [NCORE];
  logic               m_blk_v [BDEP];
  logic [1:0]         m_blk_c [BDEP];
  logic [TASK_W-1:0]  m_blk_t [BDEP];

  sched_res_t expected_q[$];
  int errors = 0;
  int watch_rate = 0; // 0 never stall output
  logic stall_in = 1'b1;

  task automatic mirror_reset();
    m_active = AC_RESET;
    for (int c = 0; c < NCORE; c++) begin
      m_quant[c] = QUANT_RESET; m_fill[c] = 0; m_head[c] = 0; m_load[c] = 0;
      m_run_v[c] = 1'b0; m_run_id[c] = '0; m_slice[c] = 0;
    end
    for (int b = 0; b < BDEP; b++) begin
      m_blk_v[b] = 1'b0; m_blk_c[b] = '0; m_blk_t[b] = '0;
    end
  endtask

  function automatic bit q_push(int c, logic [TASK_W-1:0] t);
    if (m_fill[c] >= QDEP) return 1'b0;
    m_fifo[c][(m_head[c] + m_fill[c]) % QDEP] = t;
    m_fill[c]++;
    return 1'b1;
  endfunction

  function automatic logic [TASK_W-1:0] q_pop(int c);
    logic [TASK_W-1:0] t;
    t = m_fifo[c][m_head[c]];
    m_head[c] = (m_head[c] + 1) % QDEP;
    m_fill[c]--;
    return t;
  endfunction

  task automatic next_task(int c);
    m_slice[c] = m_quant[c];
    if (m_fill[c] == 0) begin
      m_run_v[c] = 1'b0; m_run_id[c] = '0;
    end else begin
      m_run_id[c] = q_pop(c); m_run_v[c] = 1'b1;
    end
  endtask

  // expected result of one scheduler event, updating the mirror
  task automatic schedule_event(cmd_t op, logic [TASK_W-1:0] t, int c, reason_t rsn,
                                output sched_res_t r);
    int n, best, k, slot;
    logic [TASK_W-1:0] cur;
    r = '0;
    case (op)
      CMD_LOAD: begin
        n = m_active;
        if (n < 1) n = 1;
        if (n > NCORE) n = NCORE;
        best = 0;
        for (int i = 1; i < n; i++) if (m_load[i] < m_load[best]) best = i;
        r.core = best[1:0];
        if (q_push(best, t)) begin
          if (m_load[best] < 1023) m_load[best]++;
        end else r.stat = ST_QFULL;
      end
      CMD_UNBLOCK: begin
        k = BDEP;
        for (int i = BDEP - 1; i >= 0; i--) if (m_blk_v[i] && m_blk_t[i] == t) k = i;
        if (k == BDEP) r.stat = ST_UNKNOWN;
        else begin
          r.core = m_blk_c[k];
          if (!q_push(m_blk_c[k], t)) r.stat = ST_QFULL;
          else begin
            // close the gap, keeping arrival order
            for (int i = k; i + 1 < BDEP; i++) begin
              m_blk_v[i] = m_blk_v[i+1]; m_blk_c[i] = m_blk_c[i+1];
              m_blk_t[i] = m_blk_t[i+1];
            end
            m_blk_v[BDEP-1] = 1'b0; m_blk_c[BDEP-1] = '0; m_blk_t[BDEP-1] = '0;
          end
        end
      end
      CMD_TICK: begin
        if (!m_run_v[c]) next_task(c);
        else if (rsn == RSN_BLOCK) begin
          slot = BDEP;
          for (int i = BDEP - 1; i >= 0; i--) if (!m_blk_v[i]) slot = i;
          if (slot == BDEP) r.stat = ST_BLKFULL;
          else begin
            m_blk_v[slot] = 1'b1; m_blk_c[slot] = c[1:0]; m_blk_t[slot] = m_run_id[c];
          end
          next_task(c);
        end else if (rsn == RSN_EXIT) begin
          if (m_load[c] > 0) m_load[c]--;
          next_task(c);
        end else if (m_slice[c] <= 1) begin
          // slice expired: rotate, pop before push so it never overflows
          cur = m_run_id[c];
          m_slice[c] = m_quant[c];
          if (m_fill[c] != 0) begin
            m_run_id[c] = q_pop(c);
            void'(q_push(c, cur));
          end
        end else m_slice[c]--;
        if (m_run_v[c]) r.task_n = m_run_id[c];
        else r.idle = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // send one item: predict, present, wait for acceptance
  // valid stays up into the next item when there is no gap
  task automatic send_item(cmd_t op, logic [TASK_W-1:0] t, logic [1:0] c, reason_t rsn);
    sched_res_t r;
    int g;
    g = stall_in ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    schedule_event(op, t, c, rsn, r);
    expected_q = {expected_q, r};
    in_valid <= 1'b1; cmd <= op; task_id <= t; core_sel <= c; tick_reason <= rsn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // wait until every result is back plus a margin for the search latency
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
    cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_ACTIVE) m_active = v[AC_W-1:0];
    else m_quant[idx - 1] = v;
  endtask

  // result checker with random backpressure
  always @(posedge clk) begin
    sched_res_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) report_mismatch("unexpected item", 1, 0);
      else begin
        w = expected_q.pop_front();
        if (run_task !== w.task_n) report_mismatch("run_task", run_task, w.task_n);
        if (run_idle !== w.idle) report_mismatch("run_idle", run_idle, w.idle);
        if (chosen_core !== w.core) report_mismatch("chosen_core", chosen_core, w.core);
        if (status !== w.stat) report_mismatch("status", status, w.stat);
      end
    end
    out_ready <= (watch_rate == 0) ? 1'b1 :
                 ($urandom_range(0, 99) >= watch_rate) ? 1'b1 :
                 ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b0;
  end

  // directed: loads placed by least load, ties to lowest, all cores
  task automatic test_load_balance();
    send_item(CMD_LOAD, 10'h000, 2'd0, RSN_PLAIN);
    send_item(CMD_LOAD, 10'h3FF, 2'd3, RSN_OTHER);
    send_item(CMD_LOAD, 10'h155, 2'd1, RSN_BLOCK);
    send_item(CMD_LOAD, 10'h2AA, 2'd2, RSN_EXIT);
    send_item(CMD_LOAD, 10'd7, 2'd0, RSN_PLAIN);
  endtask

  // directed: dispatch, block, exit, unblock, oddities
  task automatic test_tick_paths();
    send_item(CMD_TICK, '0, 2'd0, RSN_PLAIN);
    send_item(CMD_TICK, '0, 2'd0, RSN_PLAIN);
    send_item(CMD_TICK, '0, 2'd0, RSN_OTHER);
    send_item(CMD_TICK, '0, 2'd1, RSN_PLAIN);
    send_item(CMD_TICK, '0, 2'd1, RSN_BLOCK);
    send_item(CMD_UNBLOCK, 10'h3FF, 2'd0, RSN_PLAIN);
    send_item(CMD_UNBLOCK, 10'h3FF, 2'd0, RSN_PLAIN);
    send_item(CMD_TICK, '0, 2'd2, RSN_PLAIN);
    send_item(CMD_TICK, '0, 2'd2, RSN_EXIT);
    send_item(CMD_TICK, '0, 2'd2, RSN_EXIT);
    send_item(CMD_TICK, '0, 2'd3, RSN_BLOCK);
    send_item(CMD_NONE, 10'h3FF, 2'd3, RSN_OTHER);
    drain();
  endtask

  // directed: fill one core's queue to overflow and the blocked table to full
  task automatic test_overflow();
    write_reg(CFG_ACTIVE, 16'd1);
    write_reg(CFG_QUANT0, 16'd1);
    for (int i = 0; i < QDEP + 2; i++) send_item(CMD_LOAD, 10'(100 + i), 2'd0, RSN_PLAIN);
    for (int i = 0; i < BDEP + 2; i++) send_item(CMD_TICK, '0, 2'd0, RSN_BLOCK);
    send_item(CMD_UNBLOCK, 10'd100, 2'd0, RSN_PLAIN);
    for (int i = 0; i < 20; i++) send_item(CMD_UNBLOCK, 10'(101 + i % 4), 2'd0, RSN_PLAIN);
    for (int i = 0; i < 20; i++) send_item(CMD_TICK, '0, 2'd0, RSN_EXIT);
    drain();
  endtask

  // random traffic with task ids drawn from a small pool so unblocks hit
  task automatic test_random(int count);
    cmd_t op;
    int p;
    logic [TASK_W-1:0] t;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(0, 99);
      op = (p < 30) ? CMD_LOAD : (p < 45) ? CMD_UNBLOCK : (p < 97) ? CMD_TICK : CMD_NONE;
      t = ($urandom_range(0, 4) == 0) ? TASK_W'($urandom) : TASK_W'($urandom_range(0, 40));
      send_item(op, t, 2'($urandom), reason_t'(2'($urandom)));
    end
    drain();
  endtask

  task automatic test_config_sweep();
    logic [2:0] ac_vals [6] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd7, 3'd4};
    for (int ph = 0; ph < 6; ph++) begin
      watch_rate = (ph % 3 == 0) ? 0 : 40;
      stall_in = (ph % 2 == 1);
      write_reg(CFG_ACTIVE, 16'(ac_vals[ph]));
      write_reg(CFG_QUANT0, (ph == 1) ? 16'hFFFF : 16'(ph));
      write_reg(CFG_QUANT1, 16'($urandom_range(1, 4)));
      write_reg(CFG_QUANT2, (ph == 2) ? 16'd1 : 16'($urandom_range(2, 6)));
      write_reg(CFG_QUANT3, (ph == 4) ? 16'hFFFF : 16'($urandom_range(1, 3)));
      test_random(60);
    end
  endtask

  initial begin
    mirror_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_load_balance();
    test_tick_paths();
    test_overflow();
    test_config_sweep();
    if (errors == 0) $display("multicore_round_robin_scheduler_top_tb passed");
    else $display("multicore_round_robin_scheduler_top_tb failed");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("multicore_round_robin_scheduler_top_tb failed");
    $finish;
  end

endmodule
